// ===== sv/vnfd_pkg.sv =====
// ----------------------------------------------------------------------------
// vnfd_pkg
// Types and constants shared by the vertex normal format decoder.
// ----------------------------------------------------------------------------
package vnfd_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] raw_low;
        logic [31:0] raw_high;
    } t_in;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
    } t_out;

    localparam logic [2:0] MODE_FLOAT3  = 3'd0;
    localparam logic [2:0] MODE_HALF2   = 3'd1;
    localparam logic [2:0] MODE_SNORM16 = 3'd2;
    localparam logic [2:0] MODE_DEC3N   = 3'd3;
    localparam logic [2:0] MODE_UNORM8  = 3'd4;

    // per-lane decode kind
    typedef enum logic [2:0] {
        K_PASS,
        K_HALF,
        K_SN16,
        K_DEC,
        K_UN8
    } t_kind;

    localparam int LANES = 3;
    localparam int LAT   = 8;

    // divisors: snorm16 by 32767, dec3n by 511, unorm8 as 2b by 255
    localparam logic [14:0] C_SN16 = 15'd32767;
    localparam logic [14:0] C_DEC  = 15'd511;
    localparam logic [14:0] C_UN8  = 15'd255;

    // reciprocals floor(2^(P+16)/C), P = 25, 19, 18
    localparam logic [26:0] R_SN16 = 27'd67110912;
    localparam logic [26:0] R_DEC  = 27'd67240192;
    localparam logic [26:0] R_UN8  = 27'd67372036;

    // biased exponent when quotient top bit is bit 25: 152 - P
    localparam logic [8:0] E0_SN16 = 9'd127;
    localparam logic [8:0] E0_DEC  = 9'd133;
    localparam logic [8:0] E0_UN8  = 9'd134;

    localparam logic [32:0] ONE_FIX = 33'h0_4000_0000; // 1.0 in units of 2^-30

endpackage

// ===== sv/vnfd_lane.sv =====
// ----------------------------------------------------------------------------
// vnfd_lane
// One component: half widening, pass-through, or integer / constant with
// round to nearest even, followed by the unorm8 minus-one step.
// ----------------------------------------------------------------------------
module vnfd_lane (
    input  logic                 i_clk,
    input  vnfd_pkg::t_kind      i_kind,
    input  logic [15:0]          i_field,
    input  logic [31:0]          i_pass,
    output logic [31:0]          o_bits
);
    import vnfd_pkg::*;

    // stage 1: magnitude, normalize, half widen
    t_kind       r1_kind, r2_kind, r3_kind, r4_kind, r5_kind, r6_kind, r7_kind;
    logic        r1_sign, r2_sign, r3_sign, r4_sign;
    logic        r1_zero, r2_zero, r3_zero, r4_zero, r5_zero, r6_zero, r7_zero;
    logic [15:0] r1_an;
    logic [3:0]  r1_lz, r2_lz, r3_lz, r4_lz;
    logic [31:0] r1_res, r2_res, r3_res, r4_res, r5_res, r6_res, r7_res;

    logic        n1_sign, n1_zero;
    logic [15:0] n1_an;
    logic [3:0]  n1_lz;
    logic [31:0] n1_res;
    logic [15:0] mag;
    logic [9:0]  dec_abs;
    logic [4:0]  h_ex;
    logic [9:0]  h_man;
    logic [3:0]  h_lz;
    logic [10:0] h_sh;

    always_comb begin
        mag     = 16'd0;
        n1_sign = 1'b0;
        dec_abs = 10'd0;
        h_ex    = i_field[14:10];
        h_man   = i_field[9:0];
        h_lz    = 4'd0;
        h_sh    = 11'd0;
        n1_res  = i_pass;
        case (i_kind)
            K_SN16: begin
                n1_sign = i_field[15];
                mag     = i_field[15] ? (~i_field + 16'd1) : i_field;
            end
            K_DEC: begin
                n1_sign = i_field[9];
                dec_abs = i_field[9] ? (~i_field[9:0] + 10'd1) : i_field[9:0];
                mag     = {6'd0, dec_abs};
            end
            K_UN8: begin
                mag = {7'd0, i_field[7:0], 1'b0};
            end
            K_HALF: begin
                for (int k = 0; k < 10; k++) begin
                    if (h_man[k]) h_lz = 4'(9 - k);
                end
                h_sh = {1'b0, h_man} << (h_lz + 4'd1);
                if (h_ex == 5'd0) begin
                    if (h_man == 10'd0) begin
                        n1_res = {i_field[15], 31'd0};
                    end else begin
                        n1_res = {i_field[15], 8'(8'd112 - {4'd0, h_lz}), h_sh[9:0], 13'd0};
                    end
                end else if (h_ex == 5'h1F) begin
                    n1_res = {i_field[15], 8'hFF, h_man, 13'd0};
                end else begin
                    n1_res = {i_field[15], 8'({3'd0, h_ex} + 8'd112), h_man, 13'd0};
                end
            end
            default: begin
                n1_res = i_pass;
            end
        endcase
        n1_lz = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (mag[k]) n1_lz = 4'(15 - k);
        end
        n1_an   = mag << n1_lz;
        n1_zero = (mag == 16'd0);
    end

    always_ff @(posedge i_clk) begin
        r1_kind <= i_kind;
        r1_sign <= n1_sign;
        r1_zero <= n1_zero;
        r1_an   <= n1_an;
        r1_lz   <= n1_lz;
        r1_res  <= n1_res;
    end

    // stage 2: reciprocal multiply
    logic [26:0] recip;
    logic [42:0] n2_prod, r2_prod;
    logic [41:0] n2_num, r2_num;

    always_comb begin
        case (r1_kind)
            K_SN16: begin
                recip  = R_SN16;
                n2_num = 42'({r1_an, 25'd0});
            end
            K_DEC: begin
                recip  = R_DEC;
                n2_num = 42'({r1_an, 19'd0});
            end
            K_UN8: begin
                recip  = R_UN8;
                n2_num = 42'({r1_an, 18'd0});
            end
            default: begin
                recip  = 27'd0;
                n2_num = 42'd0;
            end
        endcase
        n2_prod = 43'(r1_an) * 43'(recip);
    end

    always_ff @(posedge i_clk) begin
        r2_kind <= r1_kind;
        r2_sign <= r1_sign;
        r2_zero <= r1_zero;
        r2_lz   <= r1_lz;
        r2_res  <= r1_res;
        r2_prod <= n2_prod;
        r2_num  <= n2_num;
    end

    // stage 3: quotient estimate times divisor
    logic [14:0] divr;
    logic [26:0] r3_est;
    logic [41:0] n3_qc, r3_qc, r3_num;

    always_comb begin
        case (r2_kind)
            K_SN16:  divr = C_SN16;
            K_DEC:   divr = C_DEC;
            K_UN8:   divr = C_UN8;
            default: divr = 15'd1;
        endcase
        n3_qc = 42'(r2_prod[42:16]) * 42'(divr);
    end

    always_ff @(posedge i_clk) begin
        r3_kind <= r2_kind;
        r3_sign <= r2_sign;
        r3_zero <= r2_zero;
        r3_lz   <= r2_lz;
        r3_res  <= r2_res;
        r3_est  <= r2_prod[42:16];
        r3_qc   <= n3_qc;
        r3_num  <= r2_num;
    end

    // stage 4: remainder and one correction step
    logic [14:0] divr4;
    logic [41:0] rem;
    logic [16:0] rem_lo;
    logic        corr;
    logic [26:0] n4_q, r4_q;
    logic        n4_rnz, r4_rnz;

    always_comb begin
        case (r3_kind)
            K_SN16:  divr4 = C_SN16;
            K_DEC:   divr4 = C_DEC;
            K_UN8:   divr4 = C_UN8;
            default: divr4 = 15'd1;
        endcase
        rem    = r3_num - r3_qc;
        rem_lo = rem[16:0];
        corr   = (rem_lo >= {2'd0, divr4});
        n4_q   = r3_est + {26'd0, corr};
        n4_rnz = corr ? (rem_lo != {2'd0, divr4}) : (rem_lo != 17'd0);
    end

    always_ff @(posedge i_clk) begin
        r4_kind <= r3_kind;
        r4_sign <= r3_sign;
        r4_zero <= r3_zero;
        r4_lz   <= r3_lz;
        r4_res  <= r3_res;
        r4_q    <= n4_q;
        r4_rnz  <= n4_rnz;
    end

    // stage 5: round quotient to single
    logic        hi, g5, s5, up5;
    logic [23:0] m24;
    logic [24:0] m25;
    logic [8:0]  e0, be5;
    logic [31:0] n5_res;

    always_comb begin
        case (r4_kind)
            K_SN16:  e0 = E0_SN16;
            K_DEC:   e0 = E0_DEC;
            default: e0 = E0_UN8;
        endcase
        hi  = r4_q[26];
        m24 = hi ? r4_q[26:3] : r4_q[25:2];
        g5  = hi ? r4_q[2] : r4_q[1];
        s5  = (hi ? (r4_q[1] | r4_q[0]) : r4_q[0]) | r4_rnz;
        up5 = g5 & (s5 | m24[0]);
        m25 = {1'b0, m24} + {24'd0, up5};
        be5 = e0 + {8'd0, hi} - {5'd0, r4_lz} + {8'd0, m25[24]};
        if (r4_kind == K_SN16 || r4_kind == K_DEC || r4_kind == K_UN8) begin
            if (r4_zero) begin
                n5_res = 32'd0;
            end else begin
                n5_res = {r4_sign, be5[7:0], m25[24] ? 23'd0 : m25[22:0]};
            end
        end else begin
            n5_res = r4_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_kind <= r4_kind;
        r5_zero <= r4_zero;
        r5_res  <= n5_res;
    end

    // stage 6: unorm8 fixed point minus one
    logic [3:0]  sh6;
    logic [31:0] fix6;
    logic [32:0] diff6;
    logic        n6_neg, r6_neg;
    logic [31:0] n6_mag, r6_mag;

    always_comb begin
        sh6    = 4'(r5_res[30:23] - 8'd120);
        fix6   = r5_zero ? 32'd0 : (32'({1'b1, r5_res[22:0]}) << sh6);
        diff6  = {1'b0, fix6} - ONE_FIX;
        n6_neg = diff6[32];
        n6_mag = n6_neg ? 32'(~diff6 + 33'd1) : diff6[31:0];
    end

    always_ff @(posedge i_clk) begin
        r6_kind <= r5_kind;
        r6_zero <= r5_zero;
        r6_res  <= r5_res;
        r6_neg  <= n6_neg;
        r6_mag  <= n6_mag;
    end

    // stage 7: normalize difference
    logic [4:0]  n7_lz, r7_lz;
    logic [31:0] n7_mn, r7_mn;
    logic        r7_neg;

    always_comb begin
        n7_lz = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (r6_mag[k]) n7_lz = 5'(31 - k);
        end
        n7_mn = r6_mag << n7_lz;
    end

    always_ff @(posedge i_clk) begin
        r7_kind <= r6_kind;
        r7_zero <= (r6_mag == 32'd0);
        r7_res  <= r6_res;
        r7_neg  <= r6_neg;
        r7_lz   <= n7_lz;
        r7_mn   <= n7_mn;
    end

    // stage 8: round difference and select
    logic        up8;
    logic [24:0] m8;
    logic [7:0]  be8;
    logic [31:0] n8_bits, r8_bits;

    always_comb begin
        up8 = r7_mn[7] & ((|r7_mn[6:0]) | r7_mn[8]);
        m8  = {1'b0, r7_mn[31:8]} + {24'd0, up8};
        be8 = 8'd128 - {3'd0, r7_lz} + {7'd0, m8[24]};
        if (r7_kind == K_UN8) begin
            n8_bits = r7_zero ? 32'd0 : {r7_neg, be8, m8[24] ? 23'd0 : m8[22:0]};
        end else begin
            n8_bits = r7_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_bits <= n8_bits;
    end

    assign o_bits = r8_bits;

endmodule

// ===== sv/vertex_normal_format_decode.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_format_decode
// Decodes one packed vertex attribute into three IEEE single components.
// ----------------------------------------------------------------------------
// Takes a word on every clock (o_busy stays low) and returns its result
// on o_out through the lane registers, marked by o_strobe for one cycle;
// the receiver cannot stall. Each lane runs the reciprocal-multiply divider
// (normalize, multiply, check, correct, round) and the unorm8 subtract,
// normalize and round stages, all in an eight-stage pipe per lane.
module vertex_normal_format_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  vnfd_pkg::t_in    i_in,
    output logic             o_strobe,
    output vnfd_pkg::t_out   o_out
);
    import vnfd_pkg::*;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    t_kind       kind  [LANES];
    logic [15:0] field [LANES];
    logic [31:0] pass  [LANES];
    logic [31:0] bits  [LANES];

    always_comb begin
        pass[0] = i_in.raw_low[31:0];
        pass[1] = i_in.raw_low[63:32];
        pass[2] = i_in.raw_high;
        for (int i = 0; i < LANES; i++) begin
            kind[i]  = K_PASS;
            field[i] = 16'd0;
        end
        case (i_in.mode)
            MODE_HALF2: begin
                kind[0]  = K_HALF;
                kind[1]  = K_HALF;
                field[0] = i_in.raw_low[15:0];
                field[1] = i_in.raw_low[31:16];
                pass[2]  = 32'd0;
            end
            MODE_SNORM16: begin
                for (int i = 0; i < LANES; i++) begin
                    kind[i]  = K_SN16;
                    field[i] = i_in.raw_low[16*i +: 16];
                end
            end
            MODE_DEC3N: begin
                for (int i = 0; i < LANES; i++) begin
                    kind[i]  = K_DEC;
                    field[i] = {6'd0, i_in.raw_low[10*i +: 10]};
                end
            end
            MODE_UNORM8: begin
                for (int i = 0; i < LANES; i++) begin
                    kind[i]  = K_UN8;
                    field[i] = {8'd0, i_in.raw_low[8*i +: 8]};
                end
            end
            default: begin
                for (int i = 0; i < LANES; i++) begin
                    kind[i] = K_PASS;
                end
            end
        endcase
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vnfd_lane u_lane (
            .i_clk   (i_clk),
            .i_kind  (kind[g]),
            .i_field (field[g]),
            .i_pass  (pass[g]),
            .o_bits  (bits[g])
        );
    end

    assign n_vld = {r_vld[LAT-2:0], i_start & ~o_busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_busy       = 1'b0;
    assign o_strobe     = r_vld[LAT-1];
    assign o_out.x_bits = bits[0];
    assign o_out.y_bits = bits[1];
    assign o_out.z_bits = bits[2];

endmodule

// ===== verif/vnfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnfd_checker
// Predicts and checks every decoded word of the vertex normal format decoder.
// Each accepted input word is decoded here with exact integer arithmetic.
// Each strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vnfd_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  vnfd_pkg::t_in   i_in,
    input  logic            i_strobe,
    input  vnfd_pkg::t_out  i_out,
    input  logic            i_flush,
    output int              o_pending,
    output int              o_errors
);
    import vnfd_pkg::*;

    t_out decoded_q[$];
    int   err_cnt = 0;

    assign o_pending = decoded_q.size();
    assign o_errors  = err_cnt;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0]  ex;
        logic [10:0] man;
        int          e;
        s   = {h[15], 31'd0};
        ex  = h[14:10];
        man = {1'b0, h[9:0]};
        if (ex == 5'd0) begin
            if (man == 11'd0) return s;
            e = 1;
            while (man[10] == 1'b0) begin
                man = man << 1;
                e--;
            end
            return s | (32'(e + 112) << 23) | ({22'd0, man[9:0]} << 13);
        end
        if (ex == 5'd31) return s | 32'h7F80_0000 | ({22'd0, man[9:0]} << 13);
        return s | (32'({27'd0, ex} + 112) << 23) | ({22'd0, man[9:0]} << 13);
    endfunction

    // round-to-nearest-even of num/den into a single; result is normal unless num is zero
    function automatic logic [31:0] ratio_to_single(input logic neg,
                                                   input logic [127:0] num,
                                                   input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        int           k;
        if (num == 0) return {neg, 31'd0};
        k = 0;
        while ((num << k) < (den << 23)) k++;
        q = (num << k) / den;
        r = (num << k) % den;
        if ((r << 1) > den || ((r << 1) == den && q[0])) q++;
        if (q == (128'd1 << 24)) begin
            q = q >> 1;
            k--;
        end
        return {neg, 8'(150 - k), q[22:0]};
    endfunction

    function automatic logic [31:0] snorm_div(input logic [15:0] v, input int d);
        logic [127:0] mag;
        mag = v[15] ? 128'(32768 - int'(v[14:0])) : 128'(v[14:0]);
        return ratio_to_single(v[15], mag, 128'(d));
    endfunction

    function automatic logic [31:0] unorm_to_single(input logic [7:0] b);
        logic [31:0]  q;
        logic [127:0] m;
        logic [127:0] one;
        int           sh;
        if (b == 8'd0) return ratio_to_single(1'b1, 128'd1, 128'd1);
        q   = ratio_to_single(1'b0, 128'(b) * 2, 128'd255);
        m   = {105'd0, 1'b1, q[22:0]};
        sh  = 150 - int'(q[30:23]);
        one = 128'd1 << sh;
        if (m >= one) return ratio_to_single(1'b0, m - one, one);
        return ratio_to_single(1'b1, one - m, one);
    endfunction

    function automatic t_out decode_word(input t_in w);
        t_out o;
        case (w.mode)
            MODE_HALF2: begin
                o.x_bits = widen_half(w.raw_low[15:0]);
                o.y_bits = widen_half(w.raw_low[31:16]);
                o.z_bits = 32'd0;
            end
            MODE_SNORM16: begin
                o.x_bits = snorm_div(w.raw_low[15:0], 32767);
                o.y_bits = snorm_div(w.raw_low[31:16], 32767);
                o.z_bits = snorm_div(w.raw_low[47:32], 32767);
            end
            MODE_DEC3N: begin
                o.x_bits = snorm_div({{6{w.raw_low[9]}}, w.raw_low[9:0]}, 511);
                o.y_bits = snorm_div({{6{w.raw_low[19]}}, w.raw_low[19:10]}, 511);
                o.z_bits = snorm_div({{6{w.raw_low[29]}}, w.raw_low[29:20]}, 511);
            end
            MODE_UNORM8: begin
                o.x_bits = unorm_to_single(w.raw_low[7:0]);
                o.y_bits = unorm_to_single(w.raw_low[15:8]);
                o.z_bits = unorm_to_single(w.raw_low[23:16]);
            end
            default: begin
                o.x_bits = w.raw_low[31:0];
                o.y_bits = w.raw_low[63:32];
                o.z_bits = w.raw_high;
            end
        endcase
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n) begin
            if (i_start && !i_busy) decoded_q.push_back(decode_word(i_in));
            if (i_strobe) begin
                if (decoded_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected word: x=%h y=%h z=%h",
                                 i_out.x_bits, i_out.y_bits, i_out.z_bits);
                end else begin
                    exp_w = decoded_q.pop_front();
                    if (exp_w !== i_out) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                                     exp_w.x_bits, exp_w.y_bits, exp_w.z_bits,
                                     i_out.x_bits, i_out.y_bits, i_out.z_bits);
                    end
                end
            end
        end
        if (i_flush && decoded_q.size() != 0) begin
            err_cnt += decoded_q.size();
            $display("%0d words never returned", decoded_q.size());
            decoded_q.delete();
        end
    end
endmodule

// ===== verif/tb_vertex_normal_format_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_format_decode
// Stimulus and verdict for the vertex normal format decoder.
// Directed corner words per mode, then random words with random gaps;
// checking is done by vnfd_checker.
// ----------------------------------------------------------------------------
module tb_vertex_normal_format_decode;
    import vnfd_pkg::*;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_start;
    logic   o_busy;
    t_in    i_in;
    logic   o_strobe;
    t_out   o_out;
    logic   flush;
    int     pending;
    int     errors;

    vertex_normal_format_decode dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .o_strobe(o_strobe), .o_out(o_out)
    );

    vnfd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_in(i_in), .i_strobe(o_strobe), .i_out(o_out), .i_flush(flush),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input t_in w);
        int gap;
        i_start <= 1'b1;
        i_in    <= w;
        do @(posedge i_clk); while (o_busy);
        gap = ($urandom_range(9) < 6) ? 0 :
              ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [2:0] m, input logic [63:0] lo,
                               input logic [31:0] hi);
        t_in w;
        w.mode = m;
        w.raw_low = lo;
        w.raw_high = hi;
        send_word(w);
    endtask

    initial begin
        t_in w;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in    = '0;
        flush   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fields(MODE_FLOAT3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(MODE_FLOAT3, 64'd0, 32'd0);
        // signed zero, subnormal, inf, NaN, largest half
        send_fields(MODE_HALF2, 64'hFFFF_FFFF_8000_0000, 32'hFFFF_FFFF);
        send_fields(MODE_HALF2, {32'd0, 16'h83FF, 16'h0001}, 32'd0);
        send_fields(MODE_HALF2, {32'd0, 16'hFC00, 16'h7C00}, 32'd0);
        send_fields(MODE_HALF2, {32'd0, 16'hFE01, 16'h7C01}, 32'd0);
        send_fields(MODE_HALF2, {32'd0, 16'hFBFF, 16'h3C00}, 32'd0);
        send_fields(MODE_SNORM16, {16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000}, 32'd0);
        send_fields(MODE_SNORM16, {16'h0000, 16'h0001, 16'hFFFF, 16'h8001}, 32'hFFFF_FFFF);
        send_fields(MODE_DEC3N, {34'h3_FFFF_FFFF, 10'h200, 10'h1FF, 10'h000}, 32'd0);
        send_fields(MODE_DEC3N, {34'd0, 10'h3FF, 10'h201, 10'h001}, 32'd0);
        send_fields(MODE_UNORM8, {40'hFF_FFFF_FFFF, 8'd255, 8'd128, 8'd0}, 32'd0);
        send_fields(MODE_UNORM8, {40'd0, 8'd127, 8'd1, 8'd254}, 32'd0);
        send_fields(MODE_UNORM8 + 3'd1, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF);
        send_fields(MODE_UNORM8 + 3'd2, 64'hFEDC_BA98_7654_3210, 32'h1234_5678);
        send_fields(MODE_UNORM8 + 3'd3, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);

        for (int n = 0; n < 900; n++) begin
            w.mode     = 3'($urandom_range(7));
            w.raw_low  = {$urandom, $urandom};
            w.raw_high = $urandom;
            // bias half words toward exponent extremes
            if (w.mode == MODE_HALF2 && $urandom_range(1)) begin
                w.raw_low[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
                w.raw_low[30:26] = $urandom_range(1) ? 5'h1F : 5'h00;
            end
            send_word(w);
            if (n == 450) begin
                i_start <= 1'b0;
                // let the checker log the last word before polling
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        i_start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
        flush <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
